// ===== rtl/dds_pkg.sv =====
// ----------------------------------------------------------------------------
// dds_pkg
// Types and codes shared by the discrete distribution sampler.
// ----------------------------------------------------------------------------
package dds_pkg;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_ORDER = 2'd3;

   localparam int unsigned DIST_W  = 24;
   localparam int unsigned PROB_W  = 17;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned COUNT_W = 7;

   // 1.0 in unsigned Q1.16
   localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

   typedef struct packed {
      logic [1:0]        func;
      logic [DIST_W-1:0] distance;
      logic [PROB_W-1:0] weight;
      logic [FRAC_W-1:0] uniform_sample;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0]  sampled_distance;
      logic [1:0]         status;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_RESPOND
   } state_type;

endpackage

// ===== rtl/discrete_distribution_sampler_core.sv =====
// ----------------------------------------------------------------------------
// discrete_distribution_sampler_core
// Inverse-transform sampler over a sorted cumulative probability table,
// searched by a sequenced binary search on one table read port.
// ----------------------------------------------------------------------------
//
//   channel | ports                         | moves
//   --------+-------------------------------+----------------------------------
//   req     | req_valid req_ready req_data  | clear, append or sample item
//   rsp     | rsp_valid rsp_ready rsp_data  | one result item per req item
//
// clear, append, unused codes and a sample of an empty table go from idle
// straight to respond. Otherwise a sample runs a binary search, each search
// step being one registered table read and one compare.
// req_ready is high only while idle; a stalled rsp holds the block in respond.
// reset (synchronous) empties the table at once, no clearing pass.
//
module discrete_distribution_sampler_core #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dds_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dds_pkg::rsp_type rsp_data
);
   import dds_pkg::*;

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [DIST_W-1:0] entry_distance_mem   [TABLE_DEPTH];
   logic [PROB_W-1:0] entry_cumulative_mem [TABLE_DEPTH];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PROB_W-1:0] running_sum_ff, running_sum_in;
   logic [DIST_W-1:0] last_dist_ff, last_dist_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [DIST_W-1:0] cand_ff, cand_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [DIST_W-1:0] res_dist_ff, res_dist_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [DIST_W-1:0] rd_dist_ff;
   logic [PROB_W-1:0] rd_cum_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_fire;
   logic              out_free;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [CNT_W:0]    lo_hi_sum;
   logic [IDX_W-1:0]  mid;
   logic [PROB_W:0]   wsum;
   logic [PROB_W-1:0] sum_sat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = lo_hi_sum[IDX_W:1];
   assign wr_idx    = count_ff[IDX_W-1:0];
   assign wsum      = {1'b0, running_sum_ff} + {1'b0, req_data.weight};
   assign sum_sat   = (wsum > {1'b0, PROB_ONE}) ? PROB_ONE : wsum[PROB_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.func == FUNC_SAMPLE && count_ff != '0) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = (lo_in == hi_in) ? ST_RESPOND : ST_READ;
         end
         ST_RESPOND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in       = count_ff;
      running_sum_in = running_sum_ff;
      last_dist_in   = last_dist_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      cand_in        = cand_ff;
      frac_in        = frac_ff;
      res_dist_in    = res_dist_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      wr_en          = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_dist_in   = '0;
               res_status_in = STATUS_OK;
               frac_in       = req_data.uniform_sample;
               lo_in         = '0;
               hi_in         = count_ff;
               cand_in       = last_dist_ff;
               case (req_data.func)
                  FUNC_CLEAR: begin
                     count_in       = '0;
                     running_sum_in = '0;
                  end
                  FUNC_APPEND: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        res_status_in = STATUS_FULL;
                     end else if (count_ff != '0 && req_data.distance <= last_dist_ff) begin
                        res_status_in = STATUS_ORDER;
                     end else begin
                        wr_en          = 1'b1;
                        running_sum_in = sum_sat;
                        last_dist_in   = req_data.distance;
                        count_in       = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_SAMPLE: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COMPARE: begin
            if (rd_cum_ff > {1'b0, frac_ff}) begin
               hi_in   = CNT_W'(mid);
               cand_in = rd_dist_ff;
            end else begin
               lo_in = CNT_W'(mid) + CNT_W'(1);
            end
            res_dist_in = cand_in;
         end
         ST_RESPOND: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.sampled_distance = res_dist_ff;
               rsp_data_in.status           = res_status_ff;
               rsp_data_in.entry_count      = COUNT_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_distance_mem[wr_idx]   <= req_data.distance;
         entry_cumulative_mem[wr_idx] <= sum_sat;
      end
      rd_dist_ff <= entry_distance_mem[mid];
      rd_cum_ff  <= entry_cumulative_mem[mid];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         running_sum_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         running_sum_ff <= running_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      last_dist_ff  <= last_dist_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cand_ff       <= cand_in;
      frac_ff       <= frac_in;
      res_dist_ff   <= res_dist_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_COMPARE) |->
         (lo_ff < hi_ff && hi_ff <= count_ff))
      else $error("search window out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("ready while an item is in progress");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_EMPTY) |->
         (rsp_data.sampled_distance == '0 && rsp_data.entry_count == '0))
      else $error("empty status with nonzero distance or count");
`endif

endmodule
